// File: rtl/rlbe_pkg.sv
// Shared types and constants of the run-length bitfield encoder.
`timescale 1ns / 1ps
package rlbe_pkg;

  localparam int LenW          = 64;   // width of one run length
  localparam int ShortRunLimit = 16;   // runs below this, other than 1, use the 4-bit short code
  localparam int GroupW        = 7;    // payload bits per varint byte
  localparam int NumGroups     = (LenW + GroupW - 1) / GroupW;
  localparam int FrameW        = 96;   // bits one item can leave behind, pending included
  localparam int ByteCntW      = 4;    // holds up to 12 bytes per item
  localparam int TotalW        = 7;    // bit count of one frame

  // Bits carried between items of one stream.
  typedef struct packed {
    logic [6:0] pend_bits;
    logic [2:0] pend_cnt;
    logic       at_start;
  } enc_state_t;

  // What the coder hands back for one item.
  typedef struct packed {
    logic [FrameW-1:0]   bits;
    logic [ByteCntW-1:0] nbytes;
    logic                ends;
    enc_state_t          nxt;
  } coder_res_t;

endpackage

// File: rtl/rlbe_coder.sv
// Combinational coder: turns one run plus the pending bits into whole bytes.
`timescale 1ns / 1ps
module rlbe_coder (
  input  logic [rlbe_pkg::LenW-1:0] run_length,
  input  logic                      final_run,
  input  logic                      empty_stream,
  input  rlbe_pkg::enc_state_t      st,
  output rlbe_pkg::coder_res_t      res
);
  import rlbe_pkg::*;

  logic [GroupW*NumGroups-1:0] len_ext;
  logic [ByteCntW-1:0]         ng;
  logic [8*NumGroups-1:0]      vint;
  logic [8*NumGroups+1:0]      code;
  logic [TotalW-1:0]           clen;
  logic [2:0]                  hdr;
  logic [1:0]                  hlen;
  logic                        skip;
  logic [FrameW-1:0]           pre;
  logic [TotalW-1:0]           total;
  logic [ByteCntW-1:0]         nfull;
  logic [2:0]                  rem;
  logic [ByteCntW-1:0]         nb;
  logic [3:0]                  code_sh;

  always_comb begin
    len_ext = (GroupW*NumGroups)'(run_length);

    // count varint groups up to the highest nonzero one
    ng = ByteCntW'(1);
    for (int i = 1; i < NumGroups; i++) begin
      if (len_ext[GroupW*i +: GroupW] != '0) begin
        ng = ByteCntW'(i + 1);
      end
    end
    for (int i = 0; i < NumGroups; i++) begin
      if (ByteCntW'(i) < ng) begin
        vint[8*i +: 8] = {(ByteCntW'(i + 1) < ng), len_ext[GroupW*i +: GroupW]};
      end else begin
        vint[8*i +: 8] = '0;
      end
    end

    skip = st.at_start && !empty_stream && (run_length == '0);
    hdr  = st.at_start ? {skip, 2'b00} : 3'b000;
    hlen = st.at_start ? 2'd3 : 2'd0;

    if (empty_stream || skip) begin
      code = '0;
      clen = '0;
    end else if (run_length == LenW'(1)) begin
      code = (8*NumGroups+2)'(1);
      clen = TotalW'(1);
    end else if (run_length < LenW'(ShortRunLimit)) begin
      code = (8*NumGroups+2)'({run_length[3:0], 2'b10});
      clen = TotalW'(6);
    end else begin
      code = {vint, 2'b00};
      clen = TotalW'(2) + {ng, 3'b000};
    end

    code_sh = 4'(st.pend_cnt) + 4'(hlen);
    pre = FrameW'(st.pend_bits)
        | (FrameW'(hdr) << st.pend_cnt)
        | (FrameW'(code) << code_sh);
    total = TotalW'(st.pend_cnt) + TotalW'(hlen) + clen;
    nfull = total[TotalW-1:3];
    rem   = total[2:0];

    res.bits = pre;
    res.ends = empty_stream || final_run;
    if (res.ends) begin
      nb = nfull + ByteCntW'(rem != 3'd0);
      res.nbytes = (nb == '0) ? ByteCntW'(1) : nb;
      res.nxt.pend_bits = '0;
      res.nxt.pend_cnt  = '0;
      res.nxt.at_start  = 1'b1;
    end else begin
      nb = nfull;
      res.nbytes = nfull;
      res.nxt.pend_bits = pre[{nfull, 3'b000} +: 7];
      res.nxt.pend_cnt  = rem;
      res.nxt.at_start  = 1'b0;
    end
  end

endmodule

// File: rtl/run_length_bitfield_encoder_top.sv
// Top level of the run-length bitfield encoder.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_ready): one run length per item, zeros run
//   first, with in_final_run on the last run and in_empty_stream for a
//   bitfield with no runs. Output channel (out_valid/out_ready): one byte of
//   the packed stream per item, earliest bit in bit 0, out_last_byte on the
//   final zero-padded byte of each stream.
//   An accepted item lands in the input register and is coded in one
//   pass into the frame register, from which its first byte is sent.
//   Throughput: the frame register drains one byte per cycle while
//   out_ready is high; a long run with a full varint completes up to 11
//   bytes, a closing item up to 12. Items that complete no byte pass at
//   one per cycle while the frame register is empty.
//   Reset (rst_n low, synchronous): clears the item and frame valid state
//   and starts a new stream. A stalled receiver holds the current byte; the
//   input register then fills and in_ready drops until the frame drains.
module run_length_bitfield_encoder_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rlbe_pkg::LenW-1:0] in_run_length,
  input  logic                      in_final_run,
  input  logic                      in_empty_stream,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_packed_byte,
  output logic                      out_last_byte
);
  import rlbe_pkg::*;

  // input register
  logic            item_v_r;
  logic [LenW-1:0] len_r;
  logic            final_r;
  logic            empty_r;

  // stream state between items
  enc_state_t st_r;

  // frame register: bytes still to send for the item in flight
  logic [FrameW-1:0]   frame_r;
  logic [ByteCntW-1:0] frame_cnt_r;
  logic                frame_ends_r;

  coder_res_t res;
  logic       frame_take;
  logic       out_fire;

  rlbe_coder u_coder (
    .run_length   (len_r),
    .final_run    (final_r),
    .empty_stream (empty_r),
    .st           (st_r),
    .res          (res)
  );

  assign out_fire   = out_valid && out_ready;
  // load the next frame once the current one is empty or sends its last byte
  assign frame_take = item_v_r &&
                      ((frame_cnt_r == '0) ||
                       ((frame_cnt_r == ByteCntW'(1)) && out_ready));
  assign in_ready   = !item_v_r || frame_take;

  assign out_valid       = (frame_cnt_r != '0);
  assign out_packed_byte = frame_r[7:0];
  assign out_last_byte   = frame_ends_r && (frame_cnt_r == ByteCntW'(1));

  // hold the accepted item until the coder result is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_v_r <= 1'b1;
    end else if (frame_take) begin
      item_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      len_r   <= in_run_length;
      final_r <= in_final_run;
      empty_r <= in_empty_stream;
    end
  end

  // advance the stream state once per coded item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.pend_bits <= '0;
      st_r.pend_cnt  <= '0;
      st_r.at_start  <= 1'b1;
    end else if (frame_take) begin
      st_r <= res.nxt;
    end
  end

  // load a new frame, or drop the byte just sent
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_cnt_r <= '0;
    end else if (frame_take) begin
      frame_cnt_r <= res.nbytes;
    end else if (out_fire) begin
      frame_cnt_r <= frame_cnt_r - ByteCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (frame_take) begin
      frame_r      <= res.bits;
      frame_ends_r <= res.ends;
    end else if (out_fire) begin
      frame_r <= frame_r >> 8;
    end
  end

endmodule

// File: rtl/rlbe_checker.sv
// Port-level checks of the run-length bitfield encoder, bound to the top level.
`timescale 1ns / 1ps
module rlbe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_final_run,
  input logic       in_empty_stream,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_packed_byte,
  input logic       out_last_byte
);

  // no stale byte survives reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // a stalled byte holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_packed_byte) &&
                                $stable(out_last_byte))
    else $error("stalled output item changed");

  // with nothing to send the block takes input
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low while output idle");

  // a closing item accepted while the output is idle always yields a byte
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_empty_stream || in_final_run) && !out_valid
      |=> ##1 out_valid)
    else $error("closing item produced no output");

endmodule

bind run_length_bitfield_encoder_top rlbe_checker u_rlbe_checker (.*);
